[hw/rtl/uer_pkg.sv]
`timescale 1ns / 1ps

package uer_pkg;

    // Measurement phases
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_TRIG = 2'd1;
    localparam logic [1:0] PH_MEAS = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_TRIGGER_WIDTH = 2'd0;
    localparam logic [1:0] CFG_TIMEOUT       = 2'd1;
    localparam logic [1:0] CFG_SCALE         = 2'd2;

    // Register reset values; scale is 0.0343 / 2 * 10 in Q16
    localparam logic [9:0]  TRIGGER_WIDTH_RST = 10'd10;
    localparam logic [23:0] TIMEOUT_RST       = 24'd1000000;
    localparam logic [15:0] SCALE_RST         = 16'd11239;

    localparam int          DIST_W   = 18;
    localparam logic [17:0] DIST_MAX = 18'h3FFFF;

    typedef struct packed {
        logic [9:0]  trigger_width_ticks;
        logic [23:0] timeout_ticks;
        logic [15:0] scale_q16;
    } uer_cfg_t;

    typedef struct packed {
        logic action;
        logic sensor_select;
        logic echo_left;
        logic echo_right;
    } uer_item_t;

    typedef struct packed {
        logic              trigger_left;
        logic              trigger_right;
        logic              result_valid;
        logic              result_sensor;
        logic [DIST_W-1:0] distance_tenths_cm;
        logic              timed_out;
        logic              busy_res;
    } uer_result_t;

endpackage

[hw/rtl/uer_core.sv]
`timescale 1ns / 1ps

module uer_core
    import uer_pkg::*;
#(
    parameter int COUNT_WIDTH = 24
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  uer_item_t   item,
    input  uer_cfg_t    cfg,
    output uer_result_t result
);

    localparam int CW = COUNT_WIDTH;
    localparam int EW = (CW > 24) ? CW : 24;
    localparam int PW = CW + 16;
    localparam int SW = CW + DIST_W;

    logic [1:0]    phase_reg, phase_next;
    logic          active_reg, active_next;
    logic [CW-1:0] pc_reg, pc_next;
    logic [CW-1:0] ewc_reg, ewc_next;
    logic          started_reg, started_next;
    logic          prev_reg, prev_next;

    logic          echo;
    logic [CW-1:0] tw_lim;
    logic [EW-1:0] to_ext;
    logic [CW-1:0] to_lim;
    logic [CW-1:0] pc_base;
    logic [CW-1:0] pc_meas;
    logic          meas_go;
    logic [PW-1:0] prod;
    logic [SW-1:0] dist_wide;

    function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v);
        sat_inc = (v == {CW{1'b1}}) ? v : v + CW'(1);
    endfunction

    assign echo = active_reg ? item.echo_right : item.echo_left;

    // Zero limits behave as one tick; timeout clips to the counter range
    assign tw_lim = (cfg.trigger_width_ticks == '0) ? CW'(1)
                                                   : CW'(cfg.trigger_width_ticks);
    assign to_ext = EW'(cfg.timeout_ticks);

    always_comb
    begin
        if (to_ext == '0)
        begin
            to_lim = CW'(1);
        end
        else if (to_ext > EW'({CW{1'b1}}))
        begin
            to_lim = {CW{1'b1}};
        end
        else
        begin
            to_lim = to_ext[CW-1:0];
        end
    end

    // Echo width only changes while the echo is high, so the falling-edge
    // tick sees the final width in the register
    assign prod      = PW'(ewc_reg) * PW'(cfg.scale_q16);
    assign dist_wide = SW'(prod[PW-1:16]);

    always_comb
    begin
        phase_next   = phase_reg;
        active_next  = active_reg;
        pc_next      = pc_reg;
        ewc_next     = ewc_reg;
        started_next = started_reg;
        prev_next    = prev_reg;
        pc_base      = pc_reg;
        pc_meas      = pc_reg;
        meas_go      = 1'b0;

        result = '0;

        if (phase_reg == PH_TRIG)
        begin
            if (pc_reg >= tw_lim)
            begin
                meas_go = 1'b1;
                pc_base = '0;
            end
            else
            begin
                pc_next   = sat_inc(pc_reg);
                prev_next = echo;
            end
        end

        if (phase_reg == PH_MEAS || meas_go)
        begin
            phase_next = PH_MEAS;
            pc_meas    = sat_inc(pc_base);
            pc_next    = pc_meas;
            if (echo && !prev_reg)
            begin
                started_next = 1'b1;
                ewc_next     = CW'(1);
            end
            else if (echo && started_reg)
            begin
                ewc_next = sat_inc(ewc_reg);
            end

            if (!echo && prev_reg && started_reg)
            begin
                result.result_valid       = 1'b1;
                result.result_sensor      = active_reg;
                result.distance_tenths_cm = (dist_wide > SW'(DIST_MAX))
                                            ? DIST_MAX : dist_wide[DIST_W-1:0];
                phase_next                = PH_IDLE;
            end
            else if (pc_meas >= to_lim)
            begin
                result.result_valid  = 1'b1;
                result.timed_out     = 1'b1;
                result.result_sensor = active_reg;
                phase_next           = PH_IDLE;
            end
            prev_next = echo;
        end

        // Idle and the spare phase code both take a start request
        if (phase_reg != PH_TRIG && phase_reg != PH_MEAS)
        begin
            phase_next = PH_IDLE;
            if (item.action)
            begin
                active_next  = item.sensor_select;
                phase_next   = PH_TRIG;
                pc_next      = CW'(1);
                ewc_next     = '0;
                started_next = 1'b0;
                prev_next    = item.sensor_select ? item.echo_right : item.echo_left;
            end
        end

        result.trigger_left  = (phase_next == PH_TRIG) && !active_next;
        result.trigger_right = (phase_next == PH_TRIG) && active_next;
        result.busy_res      = (phase_next != PH_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            active_reg  <= 1'b0;
            pc_reg      <= '0;
            ewc_reg     <= '0;
            started_reg <= 1'b0;
            prev_reg    <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg   <= phase_next;
            active_reg  <= active_next;
            pc_reg      <= pc_next;
            ewc_reg     <= ewc_next;
            started_reg <= started_next;
            prev_reg    <= prev_next;
        end
    end

endmodule

[hw/rtl/uer_out_buf.sv]
`timescale 1ns / 1ps

module uer_out_buf
    import uer_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  uer_result_t in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output uer_result_t out_data
);

    logic        out_valid_reg;
    uer_result_t out_data_reg;
    logic        skid_valid_reg;
    uer_result_t skid_data_reg;
    logic        in_fire;

    // Ready comes from a register, so the upstream side never sees out_ready
    assign in_ready  = !skid_valid_reg;
    assign in_fire   = in_valid && !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || out_ready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= in_fire;
            end
        end
        else if (in_fire)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || out_ready)
        begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : in_data;
        end
        else if (in_fire)
        begin
            skid_data_reg <= in_data;
        end
    end

endmodule

[hw/rtl/ultrasonic_echo_ranger.sv]
// Two-channel ultrasonic ranger for HC-SR04 style sensors. Each slave-side
// request is one microsecond tick carrying both sampled echo levels and,
// optionally, a start request for one sensor; each tick gives exactly one
// result on the master side with the trigger drive levels, the busy flag and,
// on the tick a measurement ends, the distance in tenths of a centimetre
// ((echo width * scale_q16) >> 16, saturated to 18 bits) or a timeout flag.
// Throughput is one tick per clock unless the master side stalls; the result
// is registered in the output buffer. The state update and the single 24x16
// multiply sit between the tick input and the result register, and a
// two-entry output buffer keeps s_tready registered; under a master-side
// stall, ticks flow until the skid entry fills. Configuration is taken
// at any time via cfg_valid (cfg_ready is always high) but should only be
// written while no measurement is running. Starts arriving while busy are
// dropped.
`timescale 1ns / 1ps

module ultrasonic_echo_ranger
    import uer_pkg::*;
#(
    parameter int COUNT_WIDTH = 24
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [0] echo_left, [1] echo_right, [7:2] zero
    input  logic [1:0]  s_tuser,   // [0] action, [1] sensor_select

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [0] trigger_left, [1] trigger_right,
                                   // [19:2] distance_tenths_cm, [20] busy_res,
                                   // [23:21] zero
    output logic [2:0]  m_tuser,   // [0] result_valid, [1] result_sensor,
                                   // [2] timed_out

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_data
);

    uer_cfg_t    cfg_reg;
    uer_item_t   item;
    uer_result_t core_res;
    uer_result_t buf_res;
    logic        accept;

    // Configuration registers; unknown indexes are dropped
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.trigger_width_ticks <= TRIGGER_WIDTH_RST;
            cfg_reg.timeout_ticks       <= TIMEOUT_RST;
            cfg_reg.scale_q16           <= SCALE_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_TRIGGER_WIDTH: cfg_reg.trigger_width_ticks <= cfg_data[9:0];
                CFG_TIMEOUT:       cfg_reg.timeout_ticks       <= cfg_data;
                CFG_SCALE:         cfg_reg.scale_q16           <= cfg_data[15:0];
                default:           ;
            endcase
        end
    end

    assign item.action        = s_tuser[0];
    assign item.sensor_select = s_tuser[1];
    assign item.echo_left     = s_tdata[0];
    assign item.echo_right    = s_tdata[1];

    assign accept = s_tvalid && s_tready;

    uer_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (item),
        .cfg    (cfg_reg),
        .result (core_res)
    );

    uer_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (core_res),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (buf_res)
    );

    assign m_tdata = {3'b000, buf_res.busy_res, buf_res.distance_tenths_cm,
                      buf_res.trigger_right, buf_res.trigger_left};
    assign m_tuser = {buf_res.timed_out, buf_res.result_sensor, buf_res.result_valid};

endmodule

[sim/echo_range_checker.sv]
`timescale 1ns / 1ps

// Watches all three channels, keeps its own copy of the ranger state and
// registers, and checks every result against the oldest tick still waiting.
module echo_range_checker
    import uer_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic [1:0]  s_tuser,

    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,
    input  logic [2:0]  m_tuser,

    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_data,

    output int          mismatches,
    output int          pending,
    output logic        ranging
);

    localparam int REPORT_LIMIT = 10;

    logic [9:0]  trig_w;
    logic [23:0] tmo;
    logic [15:0] scale;

    logic [1:0]  ph;
    logic        act_sensor;
    logic [23:0] ph_count;
    logic [23:0] width_count;
    logic        started;
    logic        prev_echo;

    uer_result_t expected_readings[$];

    function automatic logic [23:0] count_up(input logic [23:0] v);
        return (v == '1) ? v : v + 24'd1;
    endfunction

    // One microsecond tick of the ranger; updates the local state
    function automatic uer_result_t range_tick(input uer_item_t t);
        uer_result_t r;
        logic [23:0] tw;
        logic [23:0] lim;
        logic [39:0] prod;
        logic        echo;
        r = '0;
        tw = (trig_w == '0) ? 24'd1 : {14'd0, trig_w};
        lim = (tmo == '0) ? 24'd1 : tmo;
        if (ph != PH_TRIG && ph != PH_MEAS)
        begin
            ph = PH_IDLE;
            if (t.action)
            begin
                act_sensor = t.sensor_select;
                ph = PH_TRIG;
                ph_count = 24'd1;
                width_count = '0;
                started = 1'b0;
                prev_echo = t.sensor_select ? t.echo_right : t.echo_left;
            end
        end
        else
        begin
            echo = act_sensor ? t.echo_right : t.echo_left;
            if (ph == PH_TRIG)
            begin
                if (ph_count >= tw)
                begin
                    ph = PH_MEAS;
                    ph_count = '0;
                end
                else
                begin
                    ph_count = count_up(ph_count);
                    prev_echo = echo;
                end
            end
            if (ph == PH_MEAS)
            begin
                ph_count = count_up(ph_count);
                if (echo && !prev_echo)
                begin
                    started = 1'b1;
                    width_count = 24'd1;
                end
                else if (echo && started)
                    width_count = count_up(width_count);
                // falling edge beats timeout on the same tick
                if (!echo && prev_echo && started)
                begin
                    prod = width_count * scale;
                    r.distance_tenths_cm = (prod[39:16] > DIST_MAX) ? DIST_MAX : prod[33:16];
                    r.result_valid = 1'b1;
                    r.result_sensor = act_sensor;
                    ph = PH_IDLE;
                end
                else if (ph_count >= lim)
                begin
                    r.result_valid = 1'b1;
                    r.timed_out = 1'b1;
                    r.result_sensor = act_sensor;
                    ph = PH_IDLE;
                end
                prev_echo = echo;
            end
        end
        r.trigger_left = (ph == PH_TRIG) && !act_sensor;
        r.trigger_right = (ph == PH_TRIG) && act_sensor;
        r.busy_res = (ph != PH_IDLE);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        uer_result_t seen;
        uer_result_t want;
        uer_item_t   tick;
        if (!rst_n)
        begin
            trig_w = TRIGGER_WIDTH_RST;
            tmo = TIMEOUT_RST;
            scale = SCALE_RST;
            ph = PH_IDLE;
            act_sensor = 1'b0;
            ph_count = '0;
            width_count = '0;
            started = 1'b0;
            prev_echo = 1'b0;
            expected_readings.delete();
            mismatches = 0;
        end
        else
        begin
            // results first: a result never belongs to a tick taken on the same edge
            if (m_tvalid && m_tready)
            begin
                seen.trigger_left = m_tdata[0];
                seen.trigger_right = m_tdata[1];
                seen.distance_tenths_cm = m_tdata[19:2];
                seen.busy_res = m_tdata[20];
                seen.result_valid = m_tuser[0];
                seen.result_sensor = m_tuser[1];
                seen.timed_out = m_tuser[2];
                if (expected_readings.size() == 0)
                begin
                    if (mismatches < REPORT_LIMIT)
                        $display("%0t: result with no tick outstanding", $realtime);
                    mismatches++;
                end
                else
                begin
                    want = expected_readings.pop_front();
                    if (seen !== want)
                    begin
                        if (mismatches < REPORT_LIMIT)
                        begin
                            $display("%0t: mismatch trig_l/r valid sensor dist tout busy", $realtime);
                            $display("  expected %b%b %b %b %0d %b %b", want.trigger_left,
                                     want.trigger_right, want.result_valid, want.result_sensor,
                                     want.distance_tenths_cm, want.timed_out, want.busy_res);
                            $display("  actual   %b%b %b %b %0d %b %b", seen.trigger_left,
                                     seen.trigger_right, seen.result_valid, seen.result_sensor,
                                     seen.distance_tenths_cm, seen.timed_out, seen.busy_res);
                        end
                        mismatches++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_TRIGGER_WIDTH: trig_w = cfg_data[9:0];
                    CFG_TIMEOUT:       tmo = cfg_data;
                    CFG_SCALE:         scale = cfg_data[15:0];
                    default:           ;
                endcase
            end
            if (s_tvalid && s_tready)
            begin
                tick.action = s_tuser[0];
                tick.sensor_select = s_tuser[1];
                tick.echo_left = s_tdata[0];
                tick.echo_right = s_tdata[1];
                expected_readings.push_back(range_tick(tick));
            end
        end
        pending = expected_readings.size();
        ranging = (ph != PH_IDLE);
    end

endmodule

[sim/ultrasonic_echo_ranger_test.sv]
`timescale 1ns / 1ps

// Stimulus and verdict for the two-channel ranger. Checking lives in
// echo_range_checker; this module only makes ticks, stalls and register writes.
module ultrasonic_echo_ranger_test;
    import uer_pkg::*;

    localparam int ITEM_TARGET    = 1450;
    localparam int HOLD_CYCLES    = 64;     // long result-side hold-off
    localparam int STALL_LIMIT    = 2000;   // cycles with no request taken anywhere

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;

    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;   // [0] echo_left, [1] echo_right
    logic [1:0]  s_tuser = '0;   // [0] action, [1] sensor_select

    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;        // [0] trig_l, [1] trig_r, [19:2] distance, [20] busy
    logic [2:0]  m_tuser;        // [0] result_valid, [1] result_sensor, [2] timed_out

    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [23:0] cfg_data = '0;

    int          mismatches;
    int          pending;
    logic        ranging;

    bit          steady;         // no idling on either side while set
    bit          hold_req;       // asks the result side for one long hold-off
    int          sent;
    logic [9:0]  cur_tw = TRIGGER_WIDTH_RST;
    int          quiet_cycles = 0;

    always #5 clk = ~clk;

    ultrasonic_echo_ranger uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    echo_range_checker range_check
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .pending    (pending),
        .ranging    (ranging)
    );

    // One tick request. Called at a rising edge; returns at the edge that took it.
    // Valid is only dropped when a gap is drawn, so back-to-back ticks keep it high.
    task automatic send_tick(input logic act, input logic sel, input logic el,
                             input logic er);
        int gap;
        gap = steady ? 0 : $urandom_range(3);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, er, el};
        s_tuser  <= {sel, act};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sent++;
    endtask

    // Tick with a chosen level on one sensor; the other echo is random
    task automatic drive_echo(input logic act, input logic pick, input logic sensor,
                              input logic level);
        logic stray;
        stray = 1'($urandom_range(1));
        if (sensor)
            send_tick(act, pick, stray, level);
        else
            send_tick(act, pick, level, stray);
    endtask

    // Stop offering ticks until every result is in. With finish_run set, any
    // measurement still running is first closed by toggling both echoes.
    // Model state is read at the falling edge, well clear of the update.
    task automatic settle(input bit finish_run);
        int step;
        step = 0;
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (finish_run && ranging)
        begin
            @(posedge clk);
            send_tick(1'b0, 1'b0, step[1], step[1]);
            s_tvalid <= 1'b0;
            step++;
            @(negedge clk);
        end
        while (pending != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    // Writes all three registers; only called straight after settle
    task automatic set_config(input logic [9:0] tw, input logic [23:0] lim,
                              input logic [15:0] sc);
        for (int i = 0; i < 3; i++)
        begin
            cfg_valid <= 1'b1;
            case (i)
                0:
                begin
                    cfg_index <= CFG_TRIGGER_WIDTH;
                    cfg_data  <= {14'd0, tw};
                end
                1:
                begin
                    cfg_index <= CFG_TIMEOUT;
                    cfg_data  <= lim;
                end
                default:
                begin
                    cfg_index <= CFG_SCALE;
                    cfg_data  <= {8'd0, sc};
                end
            endcase
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
        end
        cfg_valid <= 1'b0;
        cur_tw = tw;
    endtask

    // One well-formed measurement: start, trigger ticks with random echo,
    // lead ticks low, width ticks high, then the falling edge.
    // Stray starts hit the block while busy and on the tick a reading ends.
    task automatic take_reading(input logic sel, input logic echo_at_start, input int lead,
                                input int width, input bit stray_starts);
        int trig_ticks;
        trig_ticks = ((cur_tw == '0) ? 1 : int'(cur_tw)) - 1;
        drive_echo(1'b1, sel, sel, echo_at_start);
        repeat (trig_ticks)
            drive_echo(stray_starts && ($urandom_range(2) == 0), 1'($urandom_range(1)), sel,
                       1'($urandom_range(1)));
        repeat (lead)
            drive_echo(stray_starts && ($urandom_range(15) == 0), 1'($urandom_range(1)), sel,
                       1'b0);
        repeat (width)
            drive_echo(stray_starts && ($urandom_range(15) == 0), 1'($urandom_range(1)), sel,
                       1'b1);
        drive_echo(stray_starts && ($urandom_range(1) == 0), 1'($urandom_range(1)), sel, 1'b0);
    endtask

    // Result side: random back-pressure per result, plus one long hold-off
    // on request while the tick side keeps pushing.
    initial
    begin
        int gap;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            gap = steady ? 0 : $urandom_range(3);
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
        end
    end

    // Watchdog: a hang shows as a long run of cycles with nothing taken
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        logic [9:0]  tw;
        logic [23:0] lim;
        logic [15:0] sc;
        int          episode;
        int          readings;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed ---
        // idle ticks at both extremes of the fields
        send_tick(1'b0, 1'b0, 1'b0, 1'b0);
        send_tick(1'b0, 1'b1, 1'b1, 1'b1);
        // reset registers: echo already high at start, starts while busy
        take_reading(1'b0, 1'b1, 2, 5, 1'b1);
        take_reading(1'b1, 1'b0, 0, 3, 1'b0);
        // one-tick trigger; falling edge lands on the timeout tick, then a plain timeout
        settle(1'b1);
        set_config(10'd1, 24'd6, 16'hFFFF);
        take_reading(1'b0, 1'b0, 2, 3, 1'b0);
        take_reading(1'b1, 1'b0, 1, 10, 1'b0);
        // zero trigger width and zero timeout both act as one tick
        settle(1'b1);
        set_config(10'd0, 24'd0, 16'd0);
        take_reading(1'b1, 1'b0, 1, 2, 1'b0);

        // --- random episodes, each under fresh register settings ---
        // the hold-off and pause episodes always run
        episode = 0;
        while (sent < ITEM_TARGET || episode < 4)
        begin
            settle(1'b1);
            case ($urandom_range(9))
                0:       tw = 10'd0;
                1:       tw = 10'd1023;
                2:       tw = 10'($urandom_range(1023));
                default: tw = 10'($urandom_range(1, 12));
            endcase
            case ($urandom_range(9))
                0:       lim = 24'd0;
                1:       lim = 24'd1;
                2:       lim = 24'hFFFFFF;
                3:       lim = 24'($urandom());
                default: lim = 24'($urandom_range(2, 40));
            endcase
            case ($urandom_range(5))
                0:       sc = 16'd0;
                1:       sc = 16'hFFFF;
                2:       sc = SCALE_RST;
                default: sc = 16'($urandom_range(16'hFFFF));
            endcase
            set_config(tw, lim, sc);

            steady = (episode == 2) || ($urandom_range(3) == 0);
            // back up the result side so the block fills and holds off ticks
            if (episode == 2)
                hold_req = 1'b1;
            readings = (tw > 10'd64) ? 1 : $urandom_range(2, 6);
            for (int r = 0; r < readings; r++)
            begin
                if ($urandom_range(7) == 0)
                begin
                    // noise: any field, starts now and then
                    repeat ($urandom_range(5, 15))
                        send_tick($urandom_range(3) == 0, 1'($urandom_range(1)),
                                  1'($urandom_range(1)), 1'($urandom_range(1)));
                end
                else
                    take_reading(1'($urandom_range(1)), 1'($urandom_range(1)),
                                 $urandom_range(6), $urandom_range(1, 24),
                                 1'($urandom_range(1)));
                // tick side pauses until every result is home
                if ((episode == 3 && r == 0) || $urandom_range(9) == 0)
                    settle(1'b0);
            end
            steady = 1'b0;
            episode++;
        end

        settle(1'b0);
        repeat (10) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
